// ===== design/seven_segment_scan_animator_unit_assert.svh =====
// Assertion macros used by the checker file of the scan animator.
`ifndef SEVEN_SEGMENT_SCAN_ANIMATOR_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_ANIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssa assertion failed");

// Next-cycle implication.
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssa assertion failed");

`endif

// ===== design/ssa_pkg.sv =====
// Types, constants and the character decoder of the scan animator.
package ssa_pkg;

    localparam int DIGITS         = 4;
    localparam int CHAR_W         = 8;
    localparam int SEG_W          = 7;
    localparam int COUNT_W        = 5;
    localparam int DELAY_W        = 16;
    localparam int SCAN_W         = 2;
    localparam int SCAN_TICKS     = 2;
    localparam int FRAMES_DEFAULT = 16;
    localparam int CFG_W          = 16;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd250;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_LOAD_PRI = 2'd1,
        CMD_LOAD_SEC = 2'd2,
        CMD_START    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_FRAME_COUNT      = 2'd0,
        REG_FRAME_DELAY      = 2'd1,
        REG_NEXT_FRAME_COUNT = 2'd2,
        REG_NEXT_FRAME_DELAY = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        SHOW_KEEP,
        SHOW_FRAME,
        SHOW_TEXT
    } show_t;

    typedef logic [DIGITS-1:0][CHAR_W-1:0] row_t;

    typedef struct packed {
        logic              valid;
        show_t             kind;
        logic [1:0]        digit;
        logic [DIGITS-1:0] sel;
    } scan_req_t;

    typedef struct packed {
        logic [1:0]        bank_we;
        logic [1:0]        lane;
        logic [CHAR_W-1:0] data;
    } mem_wr_t;

    // "EN0R", first digit in the low byte
    localparam row_t DEFAULT_TEXT = {8'h52, 8'h30, 8'h4E, 8'h45};

    localparam logic [SEG_W-1:0] SEG_TABLE [36] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h10, 7'h0E,
        7'h7A, 7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h3E, 7'h62, 7'h6A, 7'h36, 7'h6E, 7'h49
    };

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    function automatic logic [SEG_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
        logic [5:0] idx;
        logic       hit;
        idx = '0;
        hit = 1'b1;
        if (c >= CH_0 && c <= CH_9)
            idx = 6'(c - CH_0);
        else if (c >= CH_UP_A && c <= CH_UP_Z)
            idx = 6'(c - CH_UP_A + LETTER_BASE);
        else if (c >= CH_LOW_A && c <= CH_LOW_Z)
            idx = 6'(c - CH_LOW_A + LETTER_BASE);
        else
            hit = 1'b0;
        return hit ? SEG_TABLE[idx] : '0;
    endfunction

endpackage

// ===== design/ssa_frame_bank.sv =====
// One physical frame bank: a row of four characters per frame, byte writes.
module ssa_frame_bank #(
    parameter int FRAMES = ssa_pkg::FRAMES_DEFAULT,
    localparam int FW = $clog2(FRAMES)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic                    re,
    input  logic [FW-1:0]           addr,
    input  logic [1:0]              lane,
    input  logic [ssa_pkg::CHAR_W-1:0] wdata,
    output ssa_pkg::row_t           rdata
);

    ssa_pkg::row_t frame_mem [FRAMES];
    ssa_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            frame_mem[addr][lane] <= wdata;
        if (re)
            rdata_reg <= frame_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ssa_ctrl.sv =====
// Command decode, config registers, scan and animation state, bank mapping.
module ssa_ctrl #(
    parameter int FRAMES = ssa_pkg::FRAMES_DEFAULT,
    localparam int FW = $clog2(FRAMES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  cmd,
    input  logic [3:0]                  frame_index,
    input  logic [1:0]                  digit_index,
    input  logic [ssa_pkg::CHAR_W-1:0]  char_code,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ssa_pkg::CFG_W-1:0]   cfg_data,
    output logic [FW-1:0]               mem_addr,
    output logic                        mem_re,
    output ssa_pkg::mem_wr_t            mem_wr,
    output ssa_pkg::scan_req_t          req
);

    localparam int CW = ssa_pkg::COUNT_W;
    localparam int DW = ssa_pkg::DELAY_W;
    localparam int ND = ssa_pkg::DIGITS;

    logic [CW-1:0] frame_count_reg, frame_count_next;
    logic [DW-1:0] frame_delay_reg, frame_delay_next;
    logic [CW-1:0] next_frame_count_reg, next_frame_count_next;
    logic [DW-1:0] next_frame_delay_reg, next_frame_delay_next;
    logic [ssa_pkg::SCAN_W-1:0] scan_cd_reg, scan_cd_next;
    logic [1:0]    scan_digit_reg, scan_digit_next;
    logic [DW-1:0] delay_left_reg, delay_left_next;
    logic [CW-1:0] frame_pos_reg, frame_pos_next;
    logic [CW-1:0] live_count_reg, live_count_next;
    logic [DW-1:0] live_delay_reg, live_delay_next;
    logic [CW-1:0] pending_count_reg, pending_count_next;
    logic [DW-1:0] pending_delay_reg, pending_delay_next;
    logic [FRAMES-1:0][ND-1:0] own_reg, own_next;
    logic [FRAMES-1:0][ND-1:0] shared_reg, shared_next;

    always_comb
    begin
        logic [DW-1:0] dl_tick;
        logic          take;
        logic [CW-1:0] show_pos;
        logic          in_range;
        logic          is_load;
        logic [ND-1:0] row_own;
        logic [ND-1:0] row_shared;
        logic          bank;

        frame_count_next      = frame_count_reg;
        frame_delay_next      = frame_delay_reg;
        next_frame_count_next = next_frame_count_reg;
        next_frame_delay_next = next_frame_delay_reg;
        scan_cd_next          = scan_cd_reg;
        scan_digit_next       = scan_digit_reg;
        delay_left_next       = delay_left_reg;
        frame_pos_next        = frame_pos_reg;
        live_count_next       = live_count_reg;
        live_delay_next       = live_delay_reg;
        pending_count_next    = pending_count_reg;
        pending_delay_next    = pending_delay_reg;
        own_next              = own_reg;
        shared_next           = shared_reg;
        mem_wr                = '0;
        req                   = '0;
        take                  = 1'b0;
        bank                  = 1'b0;

        dl_tick  = (delay_left_reg != '0) ? delay_left_reg - 1'b1 : delay_left_reg;
        show_pos = (live_count_reg == CW'(1) || frame_pos_reg == '0) ? '0 : frame_pos_reg;
        in_range = (32'(frame_index) < FRAMES);
        is_load  = (cmd == ssa_pkg::CMD_LOAD_PRI) || (cmd == ssa_pkg::CMD_LOAD_SEC);
        mem_addr = is_load ? FW'(frame_index) : FW'(show_pos);
        row_own    = own_reg[mem_addr];
        row_shared = shared_reg[mem_addr];

        if (cfg_we)
        begin
            unique case (cfg_index)
                ssa_pkg::REG_FRAME_COUNT:      frame_count_next      = CW'(cfg_data);
                ssa_pkg::REG_FRAME_DELAY:      frame_delay_next      = cfg_data;
                ssa_pkg::REG_NEXT_FRAME_COUNT: next_frame_count_next = CW'(cfg_data);
                ssa_pkg::REG_NEXT_FRAME_DELAY: next_frame_delay_next = cfg_data;
                default: ;
            endcase
        end

        if (accept)
        begin
            unique case (cmd)
                ssa_pkg::CMD_LOAD_PRI:
                begin
                    if (in_range)
                    begin
                        // a shared entry splits off into the other bank
                        bank = row_shared[digit_index] ? ~row_own[digit_index]
                                                       : row_own[digit_index];
                        own_next[mem_addr][digit_index]    = bank;
                        shared_next[mem_addr][digit_index] = 1'b0;
                        mem_wr.bank_we = bank ? 2'b10 : 2'b01;
                    end
                end
                ssa_pkg::CMD_LOAD_SEC:
                begin
                    if (in_range)
                    begin
                        bank = ~row_own[digit_index];
                        shared_next[mem_addr][digit_index] = 1'b0;
                        mem_wr.bank_we = bank ? 2'b10 : 2'b01;
                    end
                end
                ssa_pkg::CMD_START:
                begin
                    live_count_next    = (32'(frame_count_reg) > FRAMES) ? CW'(FRAMES)
                                                                        : frame_count_reg;
                    live_delay_next    = frame_delay_reg;
                    delay_left_next    = frame_delay_reg;
                    frame_pos_next     = '0;
                    pending_count_next = (32'(next_frame_count_reg) > FRAMES) ? CW'(FRAMES)
                                                                             : next_frame_count_reg;
                    pending_delay_next = next_frame_delay_reg;
                end
                ssa_pkg::CMD_TICK:
                begin
                    delay_left_next = dl_tick;
                    if (scan_cd_reg != '0)
                    begin
                        scan_cd_next = scan_cd_reg - 1'b1;
                        if (scan_cd_reg == ssa_pkg::SCAN_W'(1))
                        begin
                            scan_cd_next    = ssa_pkg::SCAN_W'(ssa_pkg::SCAN_TICKS);
                            scan_digit_next = scan_digit_reg + 2'd1;
                            req.valid       = 1'b1;
                            req.digit       = scan_digit_reg;
                            req.kind        = ssa_pkg::SHOW_KEEP;
                            if (live_count_reg == '0)
                                req.kind = ssa_pkg::SHOW_TEXT;
                            else if (live_count_reg == CW'(1))
                            begin
                                if (dl_tick == '0)
                                begin
                                    if (pending_count_reg != '0)
                                    begin
                                        take            = 1'b1;
                                        delay_left_next = pending_delay_reg;
                                    end
                                    frame_pos_next = '0;
                                end
                                req.kind = ssa_pkg::SHOW_FRAME;
                            end
                            else if (frame_pos_reg == '0)
                            begin
                                req.kind        = ssa_pkg::SHOW_FRAME;
                                delay_left_next = live_delay_reg;
                                frame_pos_next  = CW'(1);
                            end
                            else if (dl_tick == '0)
                            begin
                                if (frame_pos_reg >= live_count_reg
                                    || 32'(frame_pos_reg) >= FRAMES)
                                begin
                                    take           = (pending_count_reg != '0);
                                    frame_pos_next = '0;
                                end
                                else
                                begin
                                    req.kind        = ssa_pkg::SHOW_FRAME;
                                    delay_left_next = live_delay_reg;
                                    frame_pos_next  = frame_pos_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // switch to the secondary animation: remap rows instead of copying
        if (take)
        begin
            live_count_next    = pending_count_reg;
            live_delay_next    = pending_delay_reg;
            pending_count_next = '0;
            for (int f = 0; f < FRAMES; f++)
            begin
                if (32'(f) < 32'(pending_count_reg))
                begin
                    own_next[f]    = own_reg[f] ^ ~shared_reg[f];
                    shared_next[f] = '1;
                end
            end
        end

        req.sel     = take ? (row_own ^ ~row_shared) : row_own;
        mem_re      = req.valid && (req.kind == ssa_pkg::SHOW_FRAME);
        mem_wr.lane = digit_index;
        mem_wr.data = char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg      <= '0;
            frame_delay_reg      <= ssa_pkg::DELAY_RESET;
            next_frame_count_reg <= '0;
            next_frame_delay_reg <= ssa_pkg::DELAY_RESET;
            scan_cd_reg          <= ssa_pkg::SCAN_W'(ssa_pkg::SCAN_TICKS);
            scan_digit_reg       <= '0;
            delay_left_reg       <= '0;
            frame_pos_reg        <= '0;
            live_count_reg       <= '0;
            live_delay_reg       <= '0;
            pending_count_reg    <= '0;
            pending_delay_reg    <= '0;
            own_reg              <= '0;
            shared_reg           <= '0;
        end
        else
        begin
            frame_count_reg      <= frame_count_next;
            frame_delay_reg      <= frame_delay_next;
            next_frame_count_reg <= next_frame_count_next;
            next_frame_delay_reg <= next_frame_delay_next;
            scan_cd_reg          <= scan_cd_next;
            scan_digit_reg       <= scan_digit_next;
            delay_left_reg       <= delay_left_next;
            frame_pos_reg        <= frame_pos_next;
            live_count_reg       <= live_count_next;
            live_delay_reg       <= live_delay_next;
            pending_count_reg    <= pending_count_next;
            pending_delay_reg    <= pending_delay_next;
            own_reg              <= own_next;
            shared_reg           <= shared_next;
        end
    end

endmodule

// ===== design/ssa_out.sv =====
// Shown characters, segment decode and the result register with stall.
module ssa_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssa_pkg::scan_req_t              req,
    input  ssa_pkg::row_t                   rd0,
    input  ssa_pkg::row_t                   rd1,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [ssa_pkg::DIGITS-1:0]      digit_select_n,
    output logic [ssa_pkg::SEG_W-1:0]       segments_n,
    output logic                            hold
);

    logic                       s1_valid_reg, s1_valid_next;
    ssa_pkg::show_t             s1_kind_reg;
    logic [1:0]                 s1_digit_reg;
    logic [ssa_pkg::DIGITS-1:0] s1_sel_reg;
    ssa_pkg::row_t              shown_reg, shown_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ssa_pkg::DIGITS-1:0] digit_select_n_reg, digit_select_n_next;
    logic [ssa_pkg::SEG_W-1:0]  segments_n_reg, segments_n_next;
    ssa_pkg::row_t              row_chars;
    ssa_pkg::row_t              new_shown;
    logic                       s1_move;

    always_comb
    begin
        for (int d = 0; d < ssa_pkg::DIGITS; d++)
            row_chars[d] = s1_sel_reg[d] ? rd1[d] : rd0[d];

        case (s1_kind_reg)
            ssa_pkg::SHOW_FRAME: new_shown = row_chars;
            ssa_pkg::SHOW_TEXT:  new_shown = ssa_pkg::DEFAULT_TEXT;
            default:             new_shown = shown_reg;
        endcase

        s1_move = s1_valid_reg && (!out_valid_reg || !out_stall);
        hold    = s1_valid_reg && out_valid_reg && out_stall;

        s1_valid_next       = req.valid ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        shown_next          = shown_reg;
        out_valid_next      = out_valid_reg && out_stall;
        digit_select_n_next = digit_select_n_reg;
        segments_n_next     = segments_n_reg;
        if (s1_move)
        begin
            shown_next          = new_shown;
            out_valid_next      = 1'b1;
            digit_select_n_next = ~(ssa_pkg::DIGITS'(1) << s1_digit_reg);
            segments_n_next     = ~ssa_pkg::decode_char(new_shown[s1_digit_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            shown_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            shown_reg     <= shown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_kind_reg  <= req.kind;
            s1_digit_reg <= req.digit;
            s1_sel_reg   <= req.sel;
        end
        digit_select_n_reg <= digit_select_n_next;
        segments_n_reg     <= segments_n_next;
    end

    assign out_valid      = out_valid_reg;
    assign digit_select_n = digit_select_n_reg;
    assign segments_n     = segments_n_reg;

endmodule

// ===== design/seven_segment_scan_animator_unit.sv =====
// Top level of the four-digit seven-segment scan animator.
// Takes one item per clock: loads, start and ticks each update state at the accept edge.
// A tick that ends a scan interval yields one result: the accept edge reads the frame
// banks into the stage registers, and the result register then takes it; the next
// item is still taken while a result waits, until both the result register and the
// stage in front of it are full. Frames live in two banks of FRAMES rows of four
// characters; switching to the secondary animation remaps rows rather than copying,
// so there is no sweep and no clearing pass after reset. Frame slots that were never
// loaded read back as undefined characters.
module seven_segment_scan_animator_unit #(
    parameter int FRAMES = ssa_pkg::FRAMES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [3:0]                      frame_index,
    input  logic [1:0]                      digit_index,
    input  logic [ssa_pkg::CHAR_W-1:0]      char_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssa_pkg::DIGITS-1:0]      digit_select_n,
    output logic [ssa_pkg::SEG_W-1:0]       segments_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [ssa_pkg::CFG_W-1:0]       cfg_data
);

    localparam int FW = $clog2(FRAMES);

    logic               accept;
    logic               hold;
    logic [FW-1:0]      mem_addr;
    logic               mem_re;
    ssa_pkg::mem_wr_t   mem_wr;
    ssa_pkg::scan_req_t req;
    ssa_pkg::row_t      rd0;
    ssa_pkg::row_t      rd1;

    assign accept   = in_valid && !hold;
    assign in_stall = hold;

    ssa_ctrl #(.FRAMES(FRAMES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .frame_index (frame_index),
        .digit_index (digit_index),
        .char_code   (char_code),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_addr    (mem_addr),
        .mem_re      (mem_re),
        .mem_wr      (mem_wr),
        .req         (req)
    );

    ssa_frame_bank #(.FRAMES(FRAMES)) u_bank0 (
        .clk   (clk),
        .we    (mem_wr.bank_we[0]),
        .re    (mem_re),
        .addr  (mem_addr),
        .lane  (mem_wr.lane),
        .wdata (mem_wr.data),
        .rdata (rd0)
    );

    ssa_frame_bank #(.FRAMES(FRAMES)) u_bank1 (
        .clk   (clk),
        .we    (mem_wr.bank_we[1]),
        .re    (mem_re),
        .addr  (mem_addr),
        .lane  (mem_wr.lane),
        .wdata (mem_wr.data),
        .rdata (rd1)
    );

    ssa_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rd0            (rd0),
        .rd1            (rd1),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .digit_select_n (digit_select_n),
        .segments_n     (segments_n),
        .hold           (hold)
    );

endmodule

// ===== design/ssa_checker.sv =====
// Port-level checks for the scan animator, bound to the top level.
`include "seven_segment_scan_animator_unit_assert.svh"

module ssa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  cmd,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ssa_pkg::DIGITS-1:0]  digit_select_n,
    input logic [ssa_pkg::SEG_W-1:0]   segments_n
);

    `SSA_ASSERT_IMPL(a_digit_onehot, clk, rst_n, out_valid, $onehot(~digit_select_n))
    `SSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(digit_select_n) && $stable(segments_n))
    `SSA_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `SSA_ASSERT_IMPL(a_result_from_tick, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall && cmd == ssa_pkg::CMD_TICK, 2))

endmodule

bind seven_segment_scan_animator_unit ssa_checker u_ssa_checker (.*);

// ===== verif/seven_segment_scan_animator_unit_test.sv =====
// Self-checking testbench of the scan animator: queued item stimulus, predicted scan results.
module seven_segment_scan_animator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ssa_pkg::*;

    localparam int ROWS          = FRAMES_DEFAULT;
    localparam int SLOTS         = ROWS * DIGITS;
    localparam int CYCLE_NS      = 4;
    localparam int LIMIT_NS      = 2000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_BOUND   = 20000;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 29;

    localparam logic [SEG_W-1:0] GLYPHS [36] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h10, 7'h0E,
        7'h7A, 7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h3E, 7'h62, 7'h6A, 7'h36, 7'h6E, 7'h49
    };

    typedef struct packed {
        cmd_t              cmd;
        logic [3:0]        frame;
        logic [1:0]        digit;
        logic [CHAR_W-1:0] ch;
    } scan_item_t;

    typedef struct packed {
        logic [DIGITS-1:0] sel_n;
        logic [SEG_W-1:0]  seg_n;
    } scan_out_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           cmd         = '0;
    logic [3:0]           frame_index = '0;
    logic [1:0]           digit_index = '0;
    logic [CHAR_W-1:0]    char_code   = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [DIGITS-1:0]    digit_select_n;
    logic [SEG_W-1:0]     segments_n;
    logic                 cfg_we      = 1'b0;
    logic [1:0]           cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    seven_segment_scan_animator_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .frame_index    (frame_index),
        .digit_index    (digit_index),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digit_select_n (digit_select_n),
        .segments_n     (segments_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // display model state
    logic [COUNT_W-1:0] reg_frames      = '0;
    logic [DELAY_W-1:0] reg_delay       = DELAY_RESET;
    logic [COUNT_W-1:0] reg_next_frames = '0;
    logic [DELAY_W-1:0] reg_next_delay  = DELAY_RESET;
    logic [1:0]         scan_wait       = SCAN_W'(SCAN_TICKS);
    logic [1:0]         scan_pos        = '0;
    logic [DELAY_W-1:0] hold_left       = '0;
    logic [COUNT_W-1:0] frame_pos       = '0;
    logic [COUNT_W-1:0] anim_frames     = '0;
    logic [DELAY_W-1:0] anim_delay      = '0;
    logic [COUNT_W-1:0] queued_frames   = '0;
    logic [DELAY_W-1:0] queued_delay    = '0;
    logic [CHAR_W-1:0]  pri_chars [SLOTS];
    logic [CHAR_W-1:0]  sec_chars [SLOTS];
    logic [CHAR_W-1:0]  lit_chars [DIGITS] = '{default: '0};

    bit                 pri_loaded [SLOTS];
    bit                 sec_loaded [SLOTS];

    scan_item_t         send_q [$];
    scan_item_t         on_bus;
    scan_out_t          scans_due [$];
    scan_out_t          mon_want;
    int unsigned        items_queued = 0;
    int unsigned        items_taken  = 0;
    int unsigned        send_gap     = 0;
    int unsigned        stall_left   = 0;
    int unsigned        fail_count   = 0;
    bit                 long_hold_done = 1'b0;
    bit                 steady_send  = 1'b0;
    bit                 steady_recv  = 1'b0;

    function automatic logic [COUNT_W-1:0] clamp_frames(logic [COUNT_W-1:0] c);
        return (int'(c) > ROWS) ? COUNT_W'(ROWS) : c;
    endfunction

    function automatic logic [SEG_W-1:0] glyph_of(logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9)
            return GLYPHS[int'(c - CH_0)];
        if (c >= CH_UP_A && c <= CH_UP_Z)
            return GLYPHS[int'(c - CH_UP_A) + 10];
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
            return GLYPHS[int'(c - CH_LOW_A) + 10];
        return '0;
    endfunction

    task automatic show_row(int f);
        if (f < ROWS)
            for (int i = 0; i < DIGITS; i++)
                lit_chars[i] = pri_chars[f * DIGITS + i];
    endtask

    task automatic switch_to_secondary();
        int n;
        n = int'(clamp_frames(queued_frames));
        for (int s = 0; s < n * DIGITS; s++)
            pri_chars[s] = sec_chars[s];
        anim_frames   = COUNT_W'(n);
        queued_frames = '0;
        anim_delay    = queued_delay;
    endtask

    task automatic update_shown();
        if (anim_frames == 0)
        begin
            for (int i = 0; i < DIGITS; i++)
                lit_chars[i] = DEFAULT_TEXT[i];
        end
        else if (anim_frames == 1)
        begin
            if (hold_left == 0)
            begin
                if (queued_frames != 0)
                begin
                    switch_to_secondary();
                    hold_left = anim_delay;
                end
                frame_pos = '0;
            end
            show_row(0);
        end
        else if (frame_pos == 0)
        begin
            show_row(0);
            hold_left = anim_delay;
            frame_pos = COUNT_W'(1);
        end
        else if (hold_left == 0)
        begin
            if (int'(frame_pos) > int'(anim_frames) - 1 || int'(frame_pos) > ROWS - 1)
            begin
                if (queued_frames != 0)
                    switch_to_secondary();
                frame_pos = '0;
            end
            else
            begin
                show_row(int'(frame_pos));
                hold_left = anim_delay;
                frame_pos = frame_pos + 1'b1;
            end
        end
    endtask

    task automatic advance_display(scan_item_t it);
        scan_out_t o;
        int        slot;
        slot = int'(it.frame) * DIGITS + int'(it.digit);
        case (it.cmd)
            CMD_LOAD_PRI:
            begin
                if (int'(it.frame) < ROWS)
                    pri_chars[slot] = it.ch;
            end
            CMD_LOAD_SEC:
            begin
                if (int'(it.frame) < ROWS)
                    sec_chars[slot] = it.ch;
            end
            CMD_START:
            begin
                anim_frames   = clamp_frames(reg_frames);
                anim_delay    = reg_delay;
                hold_left     = reg_delay;
                frame_pos     = '0;
                queued_frames = clamp_frames(reg_next_frames);
                queued_delay  = reg_next_delay;
            end
            default:
            begin
                if (hold_left > 0)
                    hold_left = hold_left - 1'b1;
                if (scan_wait == 0)
                    return;
                scan_wait = scan_wait - 1'b1;
                if (scan_wait != 0)
                    return;
                scan_wait = SCAN_W'(SCAN_TICKS);
                update_shown();
                o.sel_n = ~(DIGITS'(1) << scan_pos);
                o.seg_n = ~glyph_of(lit_chars[scan_pos]);
                scans_due.push_back(o);
                scan_pos = scan_pos + 1'b1;
            end
        endcase
    endtask

    task automatic report_fail(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    function automatic int unsigned pick_gap(bit steady, int unsigned calm_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < calm_pct)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 4))
            0:       return CHAR_W'(CH_0 + $urandom_range(0, 9));
            1:       return CHAR_W'(CH_UP_A + $urandom_range(0, 25));
            2:       return CHAR_W'(CH_LOW_A + $urandom_range(0, 25));
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 14)
        begin
            case ($urandom_range(0, 3))
                0:       return COUNT_W'(ROWS);
                1:       return COUNT_W'(ROWS + 1);
                2:       return '1;
                default: return COUNT_W'($urandom_range(5, 31));
            endcase
        end
        if (r < 26)
            return '0;
        return COUNT_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 14)
            return '1;
        if (r < 22)
            return DELAY_W'($urandom_range(0, 65535));
        return DELAY_W'($urandom_range(1, 6));
    endfunction

    task automatic queue_item(scan_item_t it);
        send_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_load(cmd_t c, int f, int d, logic [CHAR_W-1:0] ch);
        scan_item_t it;
        it.cmd   = c;
        it.frame = 4'(f);
        it.digit = 2'(d);
        it.ch    = ch;
        if (c == CMD_LOAD_PRI)
            pri_loaded[f * DIGITS + d] = 1'b1;
        else
            sec_loaded[f * DIGITS + d] = 1'b1;
        queue_item(it);
    endtask

    task automatic queue_bare(cmd_t c);
        scan_item_t it;
        it.cmd   = c;
        it.frame = 4'($urandom_range(0, 15));
        it.digit = 2'($urandom_range(0, 3));
        it.ch    = CHAR_W'($urandom_range(0, 255));
        queue_item(it);
    endtask

    // every row the start can bring on screen gets loaded first
    task automatic queue_start();
        int s;
        int pri_rows;
        int sec_rows;
        pri_rows = int'(clamp_frames(reg_frames));
        sec_rows = int'(clamp_frames(reg_next_frames));
        for (s = 0; s < pri_rows * DIGITS; s++)
            if (!pri_loaded[s])
                queue_load(CMD_LOAD_PRI, s / DIGITS, s % DIGITS, pick_char());
        for (s = 0; s < sec_rows * DIGITS; s++)
            if (!sec_loaded[s])
                queue_load(CMD_LOAD_SEC, s / DIGITS, s % DIGITS, pick_char());
        queue_bare(CMD_START);
    endtask

    task automatic queue_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            queue_bare(CMD_TICK);
        else if (r < 82)
            queue_load(CMD_LOAD_PRI, $urandom_range(0, 15), $urandom_range(0, 3), pick_char());
        else if (r < 95)
            queue_load(CMD_LOAD_SEC, $urandom_range(0, 15), $urandom_range(0, 3), pick_char());
        else
            queue_start();
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_FRAME_COUNT:      reg_frames      = val[COUNT_W-1:0];
            REG_FRAME_DELAY:      reg_delay       = val[DELAY_W-1:0];
            REG_NEXT_FRAME_COUNT: reg_next_frames = val[COUNT_W-1:0];
            default:              reg_next_delay  = val[DELAY_W-1:0];
        endcase
    endtask

    task automatic write_config(logic [COUNT_W-1:0] fc, logic [DELAY_W-1:0] fd,
                                logic [COUNT_W-1:0] nfc, logic [DELAY_W-1:0] nfd);
        write_reg(REG_FRAME_COUNT, CFG_W'(fc));
        write_reg(REG_FRAME_DELAY, fd);
        write_reg(REG_NEXT_FRAME_COUNT, CFG_W'(nfc));
        write_reg(REG_NEXT_FRAME_DELAY, nfd);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        while ((items_taken != items_queued || scans_due.size() != 0)
               && waited < DRAIN_BOUND)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CYCLE_NS / 2) clk = ~clk;
    end

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_display(on_bus);
                items_taken++;
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled item
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (send_q.size() != 0)
            begin
                on_bus = send_q.pop_front();
                cmd         <= on_bus.cmd;
                frame_index <= on_bus.frame;
                digit_index <= on_bus.digit;
                char_code   <= on_bus.ch;
                in_valid    <= 1'b1;
                send_gap = pick_gap(steady_send, 55);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with one long hold while ticks are still waiting to go in
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0 && !long_hold_done && send_q.size() > 30
                && send_q[0].cmd == CMD_TICK)
            begin
                long_hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0)
            begin
                stall_left = pick_gap(steady_recv, 75);
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (scans_due.size() == 0)
            begin
                report_fail($sformatf("unexpected scan result: sel %h seg %h",
                                      digit_select_n, segments_n));
            end
            else
            begin
                mon_want = scans_due.pop_front();
                if (mon_want.sel_n !== digit_select_n || mon_want.seg_n !== segments_n)
                    report_fail($sformatf(
                        "scan mismatch: expected sel %h seg %h, got sel %h seg %h",
                        mon_want.sel_n, mon_want.seg_n, digit_select_n, segments_n));
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("seven_segment_scan_animator_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: default text before and after a start
        repeat (6) queue_bare(CMD_TICK);
        queue_start();
        repeat (4) queue_bare(CMD_TICK);
        settle();

        // static frame of edge codes, delays left at reset values
        write_reg(REG_FRAME_COUNT, CFG_W'(1));
        write_reg(REG_NEXT_FRAME_COUNT, CFG_W'(0));
        cfg_we <= 1'b0;
        queue_load(CMD_LOAD_PRI, 0, 0, 8'h00);
        queue_load(CMD_LOAD_PRI, 0, 1, 8'hFF);
        queue_load(CMD_LOAD_PRI, 0, 2, CH_0);
        queue_load(CMD_LOAD_PRI, 0, 3, CH_9);
        queue_start();
        repeat (8) queue_bare(CMD_TICK);
        settle();

        // saturated counts, zero delay primary, longest delay secondary
        write_config('1, '0, COUNT_W'(ROWS + 1), '1);
        queue_load(CMD_LOAD_PRI, 1, 0, CH_UP_A);
        queue_load(CMD_LOAD_PRI, 1, 1, CH_UP_Z);
        queue_load(CMD_LOAD_PRI, 1, 2, CH_LOW_A);
        queue_load(CMD_LOAD_PRI, 1, 3, CH_LOW_Z);
        queue_load(CMD_LOAD_SEC, 0, 0, CH_0 - 1'b1);
        queue_load(CMD_LOAD_SEC, 0, 1, CH_9 + 1'b1);
        queue_load(CMD_LOAD_SEC, 0, 2, CH_UP_A - 1'b1);
        queue_load(CMD_LOAD_SEC, 0, 3, CH_UP_Z + 1'b1);
        queue_load(CMD_LOAD_SEC, 1, 0, CH_LOW_A - 1'b1);
        queue_load(CMD_LOAD_SEC, 1, 1, CH_LOW_Z + 1'b1);
        queue_start();
        repeat (44) queue_bare(CMD_TICK);
        settle();

        // static frame that hands over to a secondary animation at once
        write_config(COUNT_W'(1), '0, COUNT_W'(2), DELAY_W'(1));
        queue_start();
        repeat (14) queue_bare(CMD_TICK);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv = ($urandom_range(0, 3) == 0);
            write_config(pick_count(), pick_delay(), pick_count(), pick_delay());
            queue_start();
            repeat (PHASE_ITEMS) queue_random_item();
            settle();
        end

        if (scans_due.size() != 0)
            report_fail($sformatf("%0d scan results never arrived", scans_due.size()));
        if (items_taken != items_queued)
            report_fail($sformatf("%0d items never accepted", items_queued - items_taken));
        if (fail_count == 0)
            $display("seven_segment_scan_animator_unit_test: done, clean");
        else
            $display("seven_segment_scan_animator_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ssa_pkg.sv
design/ssa_frame_bank.sv
design/ssa_ctrl.sv
design/ssa_out.sv
design/seven_segment_scan_animator_unit.sv
design/ssa_checker.sv
verif/seven_segment_scan_animator_unit_test.sv
